// ===== rtl/pws_pkg.sv =====
`timescale 1ns / 1ps
package pws_pkg;

	// field widths
	localparam int unsigned COORD_W = 24;
	localparam int unsigned COEF_W  = 16;
	localparam int unsigned TRANS_W = 21;
	localparam int unsigned SIZE_W  = 14;
	localparam int unsigned PIX_W   = 20;
	localparam int unsigned CFG_W   = 63;
	localparam int unsigned ROW_W   = 3 * COEF_W;

	// internal arithmetic widths
	localparam int unsigned PROD_W  = COORD_W + COEF_W;   // one coefficient product
	localparam int unsigned DOT_W   = PROD_W + 2;         // clip value, scale 2^-20
	localparam int unsigned NUM_W   = DOT_W + 1;          // depth plus or minus clip
	localparam int unsigned SCL_W   = NUM_W + SIZE_W + 5; // numerator times 16*size
	localparam int unsigned DIVN_W  = SCL_W + 1;          // dividend before folding
	localparam int unsigned DIVD_W  = DOT_W + 1;          // divisor, twice the depth
	localparam int unsigned QBITS   = PIX_W - 1;          // magnitude bits of quotient

	// register indexes
	localparam logic [2:0] REG_ROW_X  = 3'd0;
	localparam logic [2:0] REG_ROW_Y  = 3'd1;
	localparam logic [2:0] REG_ROW_D  = 3'd2;
	localparam logic [2:0] REG_TRANS  = 3'd3;
	localparam logic [2:0] REG_WIDTH  = 3'd4;
	localparam logic [2:0] REG_HEIGHT = 3'd5;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = 14'd1920;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 14'd1080;

	typedef struct packed {
		logic signed [COORD_W-1:0] world_x;
		logic signed [COORD_W-1:0] world_y;
		logic signed [COORD_W-1:0] world_z;
	} point_t;

	typedef struct packed {
		logic                    visible;
		logic signed [PIX_W-1:0] screen_x;
		logic signed [PIX_W-1:0] screen_y;
	} pixel_t;

endpackage

// ===== rtl/pws_dot.sv =====
`timescale 1ns / 1ps
module pws_dot (
	input  logic                                clk,
	input  logic                                advance,
	input  pws_pkg::point_t                     point,
	input  logic [pws_pkg::ROW_W-1:0]           coefs,
	input  logic [pws_pkg::TRANS_W-1:0]         trans,
	output logic signed [pws_pkg::DOT_W-1:0]    dot
);
	import pws_pkg::*;

	logic signed [PROD_W-1:0]  px_s1, py_s1, pz_s1;
	logic signed [TRANS_W-1:0] t_s1;
	logic signed [DOT_W-1:0]   dot_s2;

	// stage 1: three products
	always_ff @(posedge clk) begin
		if (advance) begin
			px_s1 <= point.world_x * signed'(coefs[COEF_W-1:0]);
			py_s1 <= point.world_y * signed'(coefs[2*COEF_W-1:COEF_W]);
			pz_s1 <= point.world_z * signed'(coefs[3*COEF_W-1:2*COEF_W]);
			t_s1  <= signed'(trans);
		end
	end

	// stage 2: sum with translation at scale 2^-20
	always_ff @(posedge clk) begin
		if (advance) begin
			dot_s2 <= DOT_W'(px_s1) + DOT_W'(py_s1) + DOT_W'(pz_s1)
				+ signed'({{(DOT_W-TRANS_W-16){t_s1[TRANS_W-1]}}, t_s1, 16'b0});
		end
	end

	assign dot = dot_s2;

endmodule

// ===== rtl/pws_div.sv =====
`timescale 1ns / 1ps
module pws_div (
	input  logic                               clk,
	input  logic                               advance,
	input  logic [pws_pkg::DIVN_W-1:0]         dividend,
	input  logic [pws_pkg::DIVD_W-1:0]         divisor,
	input  logic                               neg,
	input  logic                               sat,
	output logic signed [pws_pkg::PIX_W-1:0]   result
);
	import pws_pkg::*;

	logic [DIVN_W-1:0] rem_c [QBITS+1];
	logic [DIVD_W-1:0] b_c   [QBITS+1];
	logic [QBITS-1:0]  q_c   [QBITS+1];
	logic              neg_c [QBITS+1];
	logic              sat_c [QBITS+1];

	logic [DIVN_W-1:0] rem_q [QBITS];
	logic [DIVD_W-1:0] b_q   [QBITS];
	logic [QBITS-1:0]  q_q   [QBITS];
	logic              neg_q [QBITS];
	logic              sat_q [QBITS];

	assign rem_c[0] = dividend;
	assign b_c[0]   = divisor;
	assign q_c[0]   = '0;
	assign neg_c[0] = neg;
	assign sat_c[0] = sat;

	// one quotient bit per stage, most significant first
	for (genvar i = 0; i < QBITS; i++) begin : g_stage
		logic [DIVN_W-1:0] trial;
		logic              ge;

		assign trial = DIVN_W'(b_c[i]) << (QBITS - 1 - i);
		assign ge    = rem_c[i] >= trial;

		always_ff @(posedge clk) begin
			if (advance) begin
				rem_q[i] <= ge ? rem_c[i] - trial : rem_c[i];
				b_q[i]   <= b_c[i];
				q_q[i]   <= {q_c[i][QBITS-2:0], ge};
				neg_q[i] <= neg_c[i];
				sat_q[i] <= sat_c[i];
			end
		end

		assign rem_c[i+1] = rem_q[i];
		assign b_c[i+1]   = b_q[i];
		assign q_c[i+1]   = q_q[i];
		assign neg_c[i+1] = neg_q[i];
		assign sat_c[i+1] = sat_q[i];
	end

	// floor of a negative quotient is minus the folded quotient minus one
	always_comb begin
		if (sat_c[QBITS])
			result = neg_c[QBITS] ? {1'b1, {QBITS{1'b0}}} : {1'b0, {QBITS{1'b1}}};
		else if (neg_c[QBITS])
			result = ~{1'b0, q_c[QBITS]};
		else
			result = {1'b0, q_c[QBITS]};
	end

endmodule

// ===== rtl/perspective_world_to_screen.sv =====
`timescale 1ns / 1ps
// world-to-screen perspective projection: each transaction on the input
// carries one Q16.8 world point and yields exactly one transaction on the
// output with the visible flag and the Q16.4 pixel position, rounded to
// nearest (halves upward) and saturated; both coordinates are zero when the
// depth is below 0.001. a new point is taken every cycle while the output
// is not stalled. the pipe runs through the dot products, the depth test,
// size scaling and sign folding, the restoring divider that yields one
// quotient bit per stage, and the output register. the whole pipe
// advances together and holds while the output is stalled. matrix rows,
// translations and viewport size are written through the configuration
// port and must only change while the pipe is empty.
module perspective_world_to_screen (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  pws_pkg::point_t               in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output pws_pkg::pixel_t               out_data,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [pws_pkg::CFG_W-1:0]     cfg_data
);
	import pws_pkg::*;

	localparam int unsigned DEPTH = 5 + QBITS;

	// configuration registers
	logic [ROW_W-1:0]   row_x_q, row_y_q, row_d_q;
	logic [CFG_W-1:0]   trans_q;
	logic [SIZE_W-1:0]  width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q  <= '0;
			row_y_q  <= '0;
			row_d_q  <= '0;
			trans_q  <= '0;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_X:  row_x_q  <= cfg_data[ROW_W-1:0];
				REG_ROW_Y:  row_y_q  <= cfg_data[ROW_W-1:0];
				REG_ROW_D:  row_d_q  <= cfg_data[ROW_W-1:0];
				REG_TRANS:  trans_q  <= cfg_data;
				REG_WIDTH:  width_q  <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
				default:    ;
			endcase
		end
	end

	// whole pipe moves unless a finished result is held back
	logic advance;
	assign advance  = !(out_valid && out_stall);
	assign in_stall = !advance;

	// valid bits, one per stage; visibility joins at stage 3
	logic vld_q [DEPTH];
	logic vis_q [DEPTH-2];

	// stages 1 and 2: the three row dot products
	logic signed [DOT_W-1:0] clip_x, clip_y, clip_d;

	pws_dot u_dot_x (
		.clk(clk), .advance(advance), .point(in_data), .coefs(row_x_q),
		.trans(trans_q[TRANS_W-1:0]), .dot(clip_x)
	);
	pws_dot u_dot_y (
		.clk(clk), .advance(advance), .point(in_data), .coefs(row_y_q),
		.trans(trans_q[2*TRANS_W-1:TRANS_W]), .dot(clip_y)
	);
	pws_dot u_dot_d (
		.clk(clk), .advance(advance), .point(in_data), .coefs(row_d_q),
		.trans(trans_q[3*TRANS_W-1:2*TRANS_W]), .dot(clip_d)
	);

	// stage 3: numerators and depth test (1000*depth >= 2^20)
	logic signed [DOT_W+9:0] depth_k;
	logic                    vis_c;
	logic signed [NUM_W-1:0] numx_s3, numy_s3;
	logic signed [DOT_W-1:0] d_s3;

	assign depth_k = (DOT_W+10)'(clip_d) * (DOT_W+10)'(1000);
	assign vis_c   = depth_k >= (DOT_W+10)'(1048576);

	always_ff @(posedge clk) begin
		if (advance) begin
			numx_s3 <= NUM_W'(clip_d) + NUM_W'(clip_x);
			numy_s3 <= NUM_W'(clip_d) - NUM_W'(clip_y);
			d_s3    <= clip_d;
		end
	end

	// stage 4: scale by 16 times the viewport size
	logic signed [SCL_W-1:0] nx_s4, ny_s4;
	logic signed [DOT_W-1:0] d_s4;

	always_ff @(posedge clk) begin
		if (advance) begin
			nx_s4 <= SCL_W'(numx_s3) * SCL_W'(signed'({1'b0, width_q, 4'b0}));
			ny_s4 <= SCL_W'(numy_s3) * SCL_W'(signed'({1'b0, height_q, 4'b0}));
			d_s4  <= d_s3;
		end
	end

	// stage 5: add depth for rounding, fold the sign, check for saturation
	logic signed [DIVN_W-1:0] ax, ay;
	logic [DIVN_W-1:0]        ux, uy, blim;
	logic [DIVD_W-1:0]        b_c;
	logic [DIVN_W-1:0]        ux_s5, uy_s5;
	logic [DIVD_W-1:0]        b_s5;
	logic                     negx_s5, negy_s5, satx_s5, saty_s5;

	assign ax   = DIVN_W'(nx_s4) + DIVN_W'(d_s4);
	assign ay   = DIVN_W'(ny_s4) + DIVN_W'(d_s4);
	assign ux   = ax[DIVN_W-1] ? ~ax : ax;
	assign uy   = ay[DIVN_W-1] ? ~ay : ay;
	assign b_c  = {d_s4, 1'b0};
	assign blim = DIVN_W'(b_c) << QBITS;

	always_ff @(posedge clk) begin
		if (advance) begin
			ux_s5   <= ux;
			uy_s5   <= uy;
			b_s5    <= b_c;
			negx_s5 <= ax[DIVN_W-1];
			negy_s5 <= ay[DIVN_W-1];
			satx_s5 <= ux >= blim;
			saty_s5 <= uy >= blim;
		end
	end

	// stages 6 onward: quotient bits
	logic signed [PIX_W-1:0] qx, qy;

	pws_div u_div_x (
		.clk(clk), .advance(advance), .dividend(ux_s5), .divisor(b_s5),
		.neg(negx_s5), .sat(satx_s5), .result(qx)
	);
	pws_div u_div_y (
		.clk(clk), .advance(advance), .dividend(uy_s5), .divisor(b_s5),
		.neg(negy_s5), .sat(saty_s5), .result(qy)
	);

	// valid and visibility chains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) vld_q[i] <= 1'b0;
		end else if (advance) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < DEPTH; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			vis_q[0] <= vis_c;
			for (int i = 1; i < DEPTH - 2; i++) vis_q[i] <= vis_q[i-1];
		end
	end

	// output register
	logic   out_valid_q;
	pixel_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= vld_q[DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (vis_q[DEPTH-3]) begin
				out_data_q.visible  <= 1'b1;
				out_data_q.screen_x <= qx;
				out_data_q.screen_y <= qy;
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// a hidden point always reports the origin
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.visible |-> out_data.screen_x == '0 && out_data.screen_y == '0)
		else $error("hidden point with nonzero coordinates");

	// a finished result in the last divider stage reaches the output
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		advance && vld_q[DEPTH-1] |=> out_valid)
		else $error("result lost at output register");

	// the input is only held back by a stalled output transaction
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

endmodule

// ===== sim/tb_perspective_world_to_screen.sv =====
`timescale 1ns / 1ps
module tb_perspective_world_to_screen;
	import pws_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	point_t                in_data;
	logic                  out_valid;
	logic                  out_stall;
	pixel_t                out_data;
	logic                  cfg_we;
	logic [2:0]            cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	// own copy of the block's registers, kept in step with every write
	logic [ROW_W-1:0]      row_x_q;
	logic [ROW_W-1:0]      row_y_q;
	logic [ROW_W-1:0]      row_d_q;
	logic [CFG_W-1:0]      trans_q;
	logic [SIZE_W-1:0]     width_q;
	logic [SIZE_W-1:0]     height_q;

	pixel_t                pending_pixels[$];
	int                    errors = 0;
	int                    quiet_cycles = 0;
	bit                    no_gaps;        // stretches with neither side idling

	localparam int DRAIN_CYCLES = 40;      // pipe is 25 deep, plus margin
	localparam int STALL_LIMIT  = 5000;    // cycles without any transaction

	perspective_world_to_screen u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// one row of the matrix dotted with the point, plus its translation; scale 2^-20
	function automatic longint row_dot(input logic [ROW_W-1:0] row,
			input logic [TRANS_W-1:0] tr, input point_t p);
		longint cx, cy, cz, t, px, py, pz;
		cx = $signed(row[15:0]);
		cy = $signed(row[31:16]);
		cz = $signed(row[47:32]);
		t  = $signed(tr);
		px = p.world_x;
		py = p.world_y;
		pz = p.world_z;
		return px * cx + py * cy + pz * cz + t * 65536;
	endfunction

	// round(8*size*num/den) with halves upward, then clamp to the Q16.4 range
	function automatic logic [PIX_W-1:0] scale_to_pixel(input logic [SIZE_W-1:0] size,
			input longint num, input longint den);
		longint n, d, q;
		n = 16 * longint'(size) * num + den;
		d = 2 * den;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q = q - 1;
		if (q > 524287)
			q = 524287;
		if (q < -524288)
			q = -524288;
		return q[PIX_W-1:0];
	endfunction

	function automatic pixel_t project_point(input point_t p);
		pixel_t r;
		longint cx, cy, dep;
		cx  = row_dot(row_x_q, trans_q[20:0], p);
		cy  = row_dot(row_y_q, trans_q[41:21], p);
		dep = row_dot(row_d_q, trans_q[62:42], p);
		r = '0;
		// hidden when behind the camera or closer than 0.001
		if (dep * 1000 >= (longint'(1) << 20)) begin
			r.visible  = 1'b1;
			r.screen_x = scale_to_pixel(width_q, dep + cx, dep);
			r.screen_y = scale_to_pixel(height_q, dep - cy, dep);
		end
		return r;
	endfunction

	function automatic int draw_gap();
		return no_gaps ? 0 : $urandom_range(0, 8);
	endfunction

	// send one point; the expected pixel is queued when the transaction happens
	task automatic send_point(input point_t p);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= p;
		do @(posedge clk); while (in_stall);
		pending_pixels.push_back(project_point(p));
		@(negedge clk);
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	// wait until every expected pixel is out and the pipe has emptied
	task automatic drain_pipe();
		go_idle();
		wait (pending_pixels.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_ROW_X:  row_x_q  = val[ROW_W-1:0];
			REG_ROW_Y:  row_y_q  = val[ROW_W-1:0];
			REG_ROW_D:  row_d_q  = val[ROW_W-1:0];
			REG_TRANS:  trans_q  = val;
			REG_WIDTH:  width_q  = val[SIZE_W-1:0];
			REG_HEIGHT: height_q = val[SIZE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [ROW_W-1:0] rx, input logic [ROW_W-1:0] ry,
			input logic [ROW_W-1:0] rd, input logic [CFG_W-1:0] tr,
			input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
		drain_pipe();
		write_reg(REG_ROW_X, CFG_W'(rx));
		write_reg(REG_ROW_Y, CFG_W'(ry));
		write_reg(REG_ROW_D, CFG_W'(rd));
		write_reg(REG_TRANS, tr);
		write_reg(REG_WIDTH, CFG_W'(w));
		write_reg(REG_HEIGHT, CFG_W'(h));
	endtask

	function automatic point_t mk_point(input int x, input int y, input int z);
		point_t p;
		p.world_x = x[COORD_W-1:0];
		p.world_y = y[COORD_W-1:0];
		p.world_z = z[COORD_W-1:0];
		return p;
	endfunction

	// mostly random, sometimes an extreme or a small value
	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2, 3: return COORD_W'($urandom_range(0, 4095)) - 24'd2048;
			default: return COORD_W'($urandom());
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] rand_coef();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'd0;
			3, 4: return 16'd4096 - 16'($urandom_range(0, 8191));
			default: return COEF_W'($urandom());
		endcase
	endfunction

	function automatic logic [ROW_W-1:0] rand_row();
		return {rand_coef(), rand_coef(), rand_coef()};
	endfunction

	function automatic logic [TRANS_W-1:0] rand_trans();
		case ($urandom_range(0, 5))
			0: return 21'h0FFFFF;
			1: return 21'h100000;
			2: return 21'd0;
			default: return TRANS_W'($urandom());
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] rand_size();
		case ($urandom_range(0, 5))
			0: return 14'd1;
			1: return 14'd8192;
			2: return 14'd0;
			3: return 14'h3FFF;
			default: return SIZE_W'($urandom_range(1, 8192));
		endcase
	endfunction

	// defaults after reset: all-zero matrix, so nothing is visible
	task automatic test_reset_state();
		send_point(mk_point(0, 0, 0));
		send_point(mk_point(8388607, -8388608, 8388607));
		send_point(mk_point(-8388608, 8388607, -8388608));
	endtask

	// identity-like matrix with a unit depth coefficient on z
	task automatic test_directed();
		write_all({16'd0, 16'd0, 16'd4096}, {16'd0, 16'd4096, 16'd0},
			{16'd1, 16'd0, 16'd0}, '0, WIDTH_RST, HEIGHT_RST);
		// depth just below and just at the 0.001 threshold
		send_point(mk_point(0, 0, 1048));
		send_point(mk_point(0, 0, 1049));
		send_point(mk_point(100, -100, 1049));
		// negative depth and zero depth
		send_point(mk_point(5, 5, -1));
		send_point(mk_point(5, 5, 0));
		// extremes of every field, saturating both ways
		send_point(mk_point(8388607, 8388607, 8388607));
		send_point(mk_point(-8388608, -8388608, 8388607));
		send_point(mk_point(8388607, -8388608, 2000));
		send_point(mk_point(-8388608, 8388607, 2000));
		send_point(mk_point(0, 0, -8388608));
		// zero viewport width together with the largest height the register can hold
		write_all(row_x_q, row_y_q, row_d_q, trans_q, 14'd0, 14'h3FFF);
		send_point(mk_point(300, 300, 4000));
		send_point(mk_point(-300, 7, 8388607));
		// extreme coefficients and translations
		write_all({3{16'h7FFF}}, {3{16'h8000}}, {3{16'h7FFF}},
			{21'h0FFFFF, 21'h100000, 21'h0FFFFF}, 14'd1, 14'd8192);
		send_point(mk_point(8388607, 8388607, 8388607));
		send_point(mk_point(-8388608, -8388608, -8388608));
		send_point(mk_point(0, 0, 0));
		send_point(mk_point(1, -1, 1));
	endtask

	// random settings per phase, random points in between
	task automatic test_random_phases();
		for (int ph = 0; ph < 10; ph++) begin
			write_all(rand_row(), rand_row(), rand_row(),
				{rand_trans(), rand_trans(), rand_trans()}, rand_size(), rand_size());
			no_gaps = (ph % 3 == 1);
			for (int i = 0; i < 133; i++)
				send_point('{rand_coord(), rand_coord(), rand_coord()});
			no_gaps = 1'b0;
		end
	endtask

	// back pressure on the output side
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = draw_gap();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// result checker: each output transaction against the oldest expectation
	always @(posedge clk) begin
		pixel_t exp_px;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				exp_px = pending_pixels.pop_front();
				if (out_data.visible !== exp_px.visible) begin
					$error("visible: expected %0d, got %0d", exp_px.visible,
						out_data.visible);
					errors++;
				end
				if (out_data.screen_x !== exp_px.screen_x) begin
					$error("screen_x: expected %0d, got %0d", exp_px.screen_x,
						out_data.screen_x);
					errors++;
				end
				if (out_data.screen_y !== exp_px.screen_y) begin
					$error("screen_y: expected %0d, got %0d", exp_px.screen_y,
						out_data.screen_y);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_perspective_world_to_screen NOT OK");
			$finish;
		end
	end

	initial begin
		no_gaps      = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		cfg_we       = 1'b0;
		cfg_index    = REG_ROW_X;
		cfg_data     = '0;
		row_x_q      = '0;
		row_y_q      = '0;
		row_d_q      = '0;
		trans_q      = '0;
		width_q      = WIDTH_RST;
		height_q     = HEIGHT_RST;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_state();
		test_directed();
		test_random_phases();

		drain_pipe();
		if (errors == 0)
			$display("tb_perspective_world_to_screen OK");
		else
			$display("tb_perspective_world_to_screen NOT OK");
		$finish;
	end

endmodule
